[src/path_direction_run_length_encoder_macros.svh]
// assertion macros for the path direction run-length encoder checker
// depends on clk_i and rst_ni being visible where the macros are used
`ifndef PATH_DIRECTION_RUN_LENGTH_ENCODER_MACROS_SVH
`define PATH_DIRECTION_RUN_LENGTH_ENCODER_MACROS_SVH

// clocked assertion that is off while reset is held
`define PDRLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked assertion that is checked during reset too
`define PDRLE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[src/pdrle_pkg.sv]
// shared types and constants for the path direction run-length encoder
// no dependencies
`timescale 1ns / 1ps

package pdrle_pkg;

  // default width of a linear pixel index
  localparam int unsigned INDEX_BITS_DEF = 24;
  // run counter width and the count sent when a run saturates
  localparam int unsigned RUN_BITS = 6;
  localparam logic [RUN_BITS-1:0] RUN_MAX = 6'd63;
  // results per point: at most a saturated or closed run, a flush and a terminator
  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned NUM_BITS = 2;

  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_UP    = 2'd3
  } dir_e;

  // one command on the output stream
  typedef struct packed {
    logic                term;
    logic [RUN_BITS-1:0] count;
    dir_e                dir;
  } res_t;

  // all commands caused by one point
  typedef struct packed {
    logic [NUM_BITS-1:0]        num;
    res_t [MAX_RESULTS-1:0]     res;
  } group_t;

endpackage

[src/pdrle_step.sv]
// per-point move classification and run bookkeeping, purely combinational
// depends on pdrle_pkg
`timescale 1ns / 1ps

module pdrle_step
  import pdrle_pkg::*;
#(
  parameter int unsigned INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic [INDEX_BITS-1:0] pixel_index_i,
  input  logic                  final_point_i,
  input  logic                  have_prev_i,
  input  logic [INDEX_BITS-1:0] prev_index_i,
  input  dir_e                  run_dir_i,
  input  logic [RUN_BITS-1:0]   run_len_i,
  output group_t                grp_o,
  output logic                  have_prev_o,
  output logic [INDEX_BITS-1:0] prev_index_o,
  output dir_e                  run_dir_o,
  output logic [RUN_BITS-1:0]   run_len_o
);

  logic                  going_up;
  logic [INDEX_BITS-1:0] diff;
  dir_e                  move_dir;
  logic [RUN_BITS:0]     len_inc;
  logic                  move_emit;
  res_t                  move_res;
  res_t                  flush_res;
  res_t                  term_res;
  dir_e                  dir_mid;
  logic [RUN_BITS-1:0]   len_mid;

  // absolute index difference and move direction
  assign going_up = pixel_index_i > prev_index_i;
  assign diff     = going_up ? (pixel_index_i - prev_index_i) : (prev_index_i - pixel_index_i);
  assign len_inc  = {1'b0, run_len_i} + {{RUN_BITS{1'b0}}, 1'b1};

  always_comb begin
    if (|diff[INDEX_BITS-1:1]) begin
      move_dir = going_up ? DIR_DOWN : DIR_UP;
    end else begin
      move_dir = going_up ? DIR_RIGHT : DIR_LEFT;
    end
  end

  // run update for the move, before any end-of-path handling
  always_comb begin
    move_emit      = 1'b0;
    move_res.term  = 1'b0;
    move_res.dir   = run_dir_i;
    move_res.count = run_len_i;
    dir_mid        = run_dir_i;
    len_mid        = run_len_i;
    if (have_prev_i) begin
      if (move_dir == run_dir_i) begin
        if (len_inc[RUN_BITS]) begin
          move_emit      = 1'b1;
          move_res.count = RUN_MAX;
          len_mid        = {{(RUN_BITS-1){1'b0}}, 1'b1};
        end else begin
          len_mid = len_inc[RUN_BITS-1:0];
        end
      end else begin
        move_emit = run_len_i != '0;
        dir_mid   = move_dir;
        len_mid   = {{(RUN_BITS-1){1'b0}}, 1'b1};
      end
    end
  end

  assign flush_res.term  = 1'b0;
  assign flush_res.dir   = dir_mid;
  assign flush_res.count = len_mid;
  assign term_res.term   = 1'b1;
  assign term_res.dir    = DIR_LEFT;
  assign term_res.count  = '0;

  // pack the commands and pick the next state
  always_comb begin
    grp_o        = '0;
    have_prev_o  = 1'b1;
    prev_index_o = pixel_index_i;
    run_dir_o    = dir_mid;
    run_len_o    = len_mid;
    if (final_point_i) begin
      have_prev_o  = 1'b0;
      prev_index_o = '0;
      run_dir_o    = DIR_LEFT;
      run_len_o    = '0;
      if (move_emit) begin
        grp_o.num    = NUM_BITS'(3);
        grp_o.res[0] = move_res;
        grp_o.res[1] = flush_res;
        grp_o.res[2] = term_res;
      end else begin
        grp_o.num    = NUM_BITS'(2);
        grp_o.res[0] = flush_res;
        grp_o.res[1] = term_res;
      end
    end else if (move_emit) begin
      grp_o.num    = NUM_BITS'(1);
      grp_o.res[0] = move_res;
    end
  end

endmodule

[src/path_direction_run_length_encoder.sv]
// Path direction run-length encoder: takes one path point (linear pixel index) per
// transaction on the slave stream, tlast marking the final point, and sends move
// commands (direction and run length, terminator flag on tuser) on the master stream.
// A point is accepted every cycle while the points cause no command; the commands
// of one point (up to three) leave one per cycle from a result register while the
// master stream is ready, and a point that causes commands waits in the input
// register until the previous point's commands have all been taken.
// Depends on pdrle_pkg and pdrle_step.
`timescale 1ns / 1ps

module path_direction_run_length_encoder
  import pdrle_pkg::*;
#(
  parameter int unsigned INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [INDEX_BITS-1:0] pixel_index, zero padding above
  input  logic [((INDEX_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
  // final_point
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [1:0] move_direction, [7:2] move_count
  output logic [7:0]                          m_axis_tdata,
  // terminator
  output logic                                m_axis_tuser,
  // last_of_point
  output logic                                m_axis_tlast
);

  logic                  s1_valid_q;
  logic [INDEX_BITS-1:0] s1_idx_q;
  logic                  s1_fin_q;
  logic                  have_prev_q;
  logic [INDEX_BITS-1:0] prev_idx_q;
  dir_e                  run_dir_q;
  logic [RUN_BITS-1:0]   run_len_q;
  group_t                grp_q;
  logic                  grp_valid_q;
  logic [NUM_BITS-1:0]   pos_q;

  group_t                grp_d;
  logic                  have_prev_d;
  logic [INDEX_BITS-1:0] prev_idx_d;
  dir_e                  run_dir_d;
  logic [RUN_BITS-1:0]   run_len_d;

  logic                  out_take;
  logic                  grp_last;
  logic                  grp_free;
  logic                  s1_go;
  res_t                  sel_res;

  pdrle_step #(
    .INDEX_BITS(INDEX_BITS)
  ) u_step (
    .pixel_index_i (s1_idx_q),
    .final_point_i (s1_fin_q),
    .have_prev_i   (have_prev_q),
    .prev_index_i  (prev_idx_q),
    .run_dir_i     (run_dir_q),
    .run_len_i     (run_len_q),
    .grp_o         (grp_d),
    .have_prev_o   (have_prev_d),
    .prev_index_o  (prev_idx_d),
    .run_dir_o     (run_dir_d),
    .run_len_o     (run_len_d)
  );

  // handshake control
  assign out_take      = grp_valid_q && m_axis_tready;
  assign grp_last      = pos_q == (grp_q.num - NUM_BITS'(1));
  assign grp_free      = !grp_valid_q || (out_take && grp_last);
  assign s1_go         = s1_valid_q && ((grp_d.num == '0) || grp_free);
  assign s_axis_tready = !s1_valid_q || s1_go;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_idx_q <= s_axis_tdata[INDEX_BITS-1:0];
      s1_fin_q <= s_axis_tlast;
    end
  end

  // path and run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      prev_idx_q  <= '0;
      run_dir_q   <= DIR_LEFT;
      run_len_q   <= '0;
    end else if (s1_go) begin
      have_prev_q <= have_prev_d;
      prev_idx_q  <= prev_idx_d;
      run_dir_q   <= run_dir_d;
      run_len_q   <= run_len_d;
    end
  end

  // result register, drained one command per cycle while m_axis_tready is high
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_valid_q <= 1'b0;
      pos_q       <= '0;
    end else if (s1_go && (grp_d.num != '0)) begin
      grp_valid_q <= 1'b1;
      pos_q       <= '0;
    end else if (out_take) begin
      if (grp_last) begin
        grp_valid_q <= 1'b0;
      end
      pos_q <= pos_q + NUM_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && (grp_d.num != '0)) begin
      grp_q <= grp_d;
    end
  end

  // pick the command at the current position
  always_comb begin
    case (pos_q)
      2'd0:    sel_res = grp_q.res[0];
      2'd1:    sel_res = grp_q.res[1];
      2'd2:    sel_res = grp_q.res[2];
      default: sel_res = '0;
    endcase
  end

  assign m_axis_tvalid = grp_valid_q;
  assign m_axis_tdata  = {sel_res.count, sel_res.dir};
  assign m_axis_tuser  = sel_res.term;
  assign m_axis_tlast  = grp_last;

endmodule

[src/pdrle_checker.sv]
// port-level checks for the path direction run-length encoder, bound to the top level
// depends on path_direction_run_length_encoder_macros.svh
`timescale 1ns / 1ps
`include "path_direction_run_length_encoder_macros.svh"

module pdrle_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser,
  input logic       m_axis_tlast
);

  // nothing leaves while reset is held
  `PDRLE_ASSERT_ALWAYS(a_idle_in_reset, !rst_ni |-> !m_axis_tvalid, "output valid during reset")

  // the terminator is a zero command and closes its point's commands
  `PDRLE_ASSERT(a_term_shape, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 8'd0), "malformed terminator")

  // commands of one point follow without a gap
  `PDRLE_ASSERT(a_group_cont, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid, "gap inside a point's commands")

  // a stalled transaction holds
  `PDRLE_ASSERT(a_stall_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "output changed under stall")

endmodule

bind path_direction_run_length_encoder pdrle_checker u_pdrle_checker (.*);

[tb/sv/tb.sv]
// self-checking testbench for path_direction_run_length_encoder
// drives path points on the slave stream and checks move commands on the master stream
// depends on pdrle_pkg and the encoder rtl
`timescale 1ns / 1ps

module tb
  import pdrle_pkg::*;
;

  localparam int unsigned IDX_W = 24;
  localparam int unsigned MAX_REPORTS = 10;

  // one move command as seen on the master stream
  typedef struct packed {
    dir_e                dir;
    logic [RUN_BITS-1:0] count;
    logic                term;
    logic                last;
  } move_cmd_t;

  // chain code predictor plus the queue of commands still owed by the encoder
  class move_scoreboard;
    move_cmd_t         owed_cmds[$];
    bit                has_prev;
    logic [IDX_W-1:0]  prev_idx;
    dir_e              run_dir;
    logic [RUN_BITS-1:0] run_len;
    int unsigned       mismatches;

    function new();
      mismatches = 0;
      clear_path();
    endfunction

    function void clear_path();
      has_prev = 1'b0;
      prev_idx = '0;
      run_dir  = DIR_LEFT;
      run_len  = '0;
    endfunction

    function int pending();
      return owed_cmds.size();
    endfunction

    // work out the commands one accepted point causes
    function void note_point(logic [IDX_W-1:0] idx, logic fin);
      move_cmd_t        batch[$];
      move_cmd_t        cmd;
      logic [IDX_W-1:0] gap;
      logic [RUN_BITS:0] next_len;
      logic             grows;
      dir_e             move;
      if (has_prev) begin
        grows = idx > prev_idx;
        gap   = grows ? idx - prev_idx : prev_idx - idx;
        if (gap > 1) begin
          move = grows ? DIR_DOWN : DIR_UP;
        end else begin
          move = grows ? DIR_RIGHT : DIR_LEFT;
        end
        if (move == run_dir) begin
          next_len = {1'b0, run_len} + 1'b1;
          // run saturates at 64 steps: send 63 and restart the count
          if (next_len == 7'd64) begin
            cmd = '{run_dir, RUN_MAX, 1'b0, 1'b0};
            batch.push_back(cmd);
            next_len = 7'd1;
          end
          run_len = next_len[RUN_BITS-1:0];
        end else begin
          if (run_len != 0) begin
            cmd = '{run_dir, run_len, 1'b0, 1'b0};
            batch.push_back(cmd);
          end
          run_dir = move;
          run_len = 6'd1;
        end
      end
      prev_idx = idx;
      has_prev = 1'b1;
      // final point flushes the run, even an empty one, then the terminator
      if (fin) begin
        cmd = '{run_dir, run_len, 1'b0, 1'b0};
        batch.push_back(cmd);
        cmd = '{DIR_LEFT, 6'd0, 1'b1, 1'b0};
        batch.push_back(cmd);
        clear_path();
      end
      for (int i = 0; i < batch.size(); i++) begin
        cmd = batch[i];
        cmd.last = (i == batch.size() - 1);
        owed_cmds.push_back(cmd);
      end
    endfunction

    // compare one accepted command with the oldest owed one
    function void check_command(move_cmd_t got);
      move_cmd_t want;
      if (owed_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected command dir=%0d count=%0d term=%0b last=%0b",
                   $realtime, got.dir, got.count, got.term, got.last);
        return;
      end
      want = owed_cmds.pop_front();
      if (got.dir !== want.dir || got.count !== want.count ||
          got.term !== want.term || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $write("%0t: command mismatch expected dir=%0d count=%0d term=%0b last=%0b",
                 $realtime, want.dir, want.count, want.term, want.last);
          $display(" got dir=%0d count=%0d term=%0b last=%0b",
                   got.dir, got.count, got.term, got.last);
        end
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IDX_W-1:0] s_axis_tdata;
  logic             s_axis_tlast;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [7:0]       m_axis_tdata;
  logic             m_axis_tuser;
  logic             m_axis_tlast;

  move_scoreboard moves_sb = new();

  bit src_idle_en;
  bit sink_idle_en;
  int hold_cycles;
  int points_sent;

  path_direction_run_length_encoder #(
    .INDEX_BITS(IDX_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("path_direction_run_length_encoder regression: fail");
    $finish;
  end

  // receiver: long hold-off when asked, random idling otherwise
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_axis_tready <= !(sink_idle_en && $urandom_range(0, 99) < 21);
      end
    end
  end

  // accepted points feed the predictor
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      moves_sb.note_point(s_axis_tdata, s_axis_tlast);
  end

  // accepted commands are checked
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      moves_sb.check_command('{dir_e'(m_axis_tdata[1:0]), m_axis_tdata[7:2],
                               m_axis_tuser, m_axis_tlast});
  end

  // offer one point and hold it until the transaction completes; called at a falling edge
  task automatic send_point(input logic [IDX_W-1:0] idx, input logic fin);
    while (src_idle_en && $urandom_range(0, 99) < 21) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= idx;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    points_sent++;
    @(negedge clk_i);
  endtask

  // next point one step away in the given direction
  function automatic logic [IDX_W-1:0] step_from(logic [IDX_W-1:0] at, dir_e d);
    logic [IDX_W-1:0] stride;
    if ($urandom_range(0, 9) < 7) begin
      stride = IDX_W'($urandom_range(2, 640));
    end else begin
      stride = IDX_W'($urandom_range(2, 24'hFFFFFF));
    end
    case (d)
      DIR_LEFT:  step_from = ($urandom_range(0, 3) == 0) ? at : at - 1'b1;
      DIR_RIGHT: step_from = at + 1'b1;
      DIR_DOWN:  step_from = at + stride;
      default:   step_from = at - stride;
    endcase
  endfunction

  // well-formed path of a few direction runs, closed by a final point
  task automatic send_random_path(input int first_len);
    int               segs;
    int               seg_len;
    int               s;
    int               k;
    dir_e             d;
    logic [IDX_W-1:0] at;
    segs = $urandom_range(1, 5);
    at   = IDX_W'($urandom);
    send_point(at, 1'b0);
    for (s = 0; s < segs; s++) begin
      d = dir_e'($urandom_range(0, 3));
      if (s == 0 && first_len > 0) begin
        seg_len = first_len;
      end else if ($urandom_range(0, 9) == 0) begin
        seg_len = $urandom_range(60, 130);
      end else begin
        seg_len = $urandom_range(1, 5);
      end
      for (k = 0; k < seg_len; k++) begin
        at = step_from(at, d);
        send_point(at, s == segs - 1 && k == seg_len - 1);
      end
    end
  endtask

  // scattered points with random final flags
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) send_point(IDX_W'($urandom), $urandom_range(0, 4) == 0);
  endtask

  initial begin
    logic [IDX_W-1:0] at;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    src_idle_en   = 1'b1;
    sink_idle_en  = 1'b1;
    hold_cycles   = 0;
    points_sent   = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // single-point paths at both index extremes
    send_point(24'h000000, 1'b1);
    send_point(24'hFFFFFF, 1'b1);
    // no change counts as left, then every direction and full-width jumps
    send_point(24'h000010, 1'b0);
    send_point(24'h000010, 1'b0);
    send_point(24'h00000F, 1'b0);
    send_point(24'h000010, 1'b0);
    send_point(24'h000012, 1'b0);
    send_point(24'h000010, 1'b0);
    send_point(24'hFFFFFF, 1'b0);
    send_point(24'h000000, 1'b0);
    send_point(24'h000001, 1'b0);
    // direction change on the final point gives three commands
    send_point(24'h000000, 1'b1);
    // first move right, down and up start a run without a command
    send_point(24'd100, 1'b0);
    send_point(24'd101, 1'b1);
    send_point(24'h800000, 1'b0);
    send_point(24'h800003, 1'b0);
    send_point(24'h800006, 1'b1);
    send_point(24'd50, 1'b0);
    send_point(24'd20, 1'b1);
    send_point(24'hAAAAAA, 1'b0);
    send_point(24'h555555, 1'b1);

    // sender pauses until the encoder has sent everything owed
    s_axis_tvalid <= 1'b0;
    while (moves_sb.pending() != 0) @(negedge clk_i);

    // receiver holds off while a zigzag keeps producing commands
    src_idle_en = 1'b0;
    @(posedge clk_i);
    hold_cycles = 120;
    @(negedge clk_i);
    at = 24'h001000;
    send_point(at, 1'b0);
    for (int k = 0; k < 24; k++) begin
      at = (k % 2 == 0) ? at + 1'b1 : at - 1'b1;
      send_point(at, k == 23);
    end

    // random paths, the first one without idling and with a saturating run
    sink_idle_en = 1'b0;
    send_random_path(64);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    while (points_sent < 150) begin
      if ($urandom_range(0, 99) < 15) begin
        send_noise();
      end else begin
        send_random_path(0);
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain
    while (moves_sb.pending() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (moves_sb.mismatches == 0 && moves_sb.pending() == 0) begin
      $display("path_direction_run_length_encoder regression: pass");
    end else begin
      $display("path_direction_run_length_encoder regression: fail");
    end
    $finish;
  end

endmodule
